// ===== hw/rtl/pfa_pkg.sv =====
// Shared types and constants of the partition fit allocator.
`default_nettype none

package pfa_pkg;

   localparam int INDEX_BITS      = 4;
   localparam int SIZE_FIELD_BITS = 16;
   localparam int FIT_MODE_BITS   = 2;
   localparam int PART_COUNT_BITS = 5;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 5;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_ALLOC = 1'b1;

   localparam logic [FIT_MODE_BITS-1:0] FIT_FIRST = 2'd0;
   localparam logic [FIT_MODE_BITS-1:0] FIT_BEST  = 2'd1;
   localparam logic [FIT_MODE_BITS-1:0] FIT_WORST = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIT_MODE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PART_COUNT = 2'd1;

   typedef struct packed {
      logic                       kind;
      logic [INDEX_BITS-1:0]      part_index;
      logic [SIZE_FIELD_BITS-1:0] size;
   } req_type;

   typedef struct packed {
      logic                       granted;
      logic [INDEX_BITS-1:0]      chosen_part;
      logic [SIZE_FIELD_BITS-1:0] left_size;
   } rsp_type;

   typedef struct packed {
      logic [FIT_MODE_BITS-1:0]   fit_mode;
      logic [PART_COUNT_BITS-1:0] part_count;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/partition_fit_allocator_unit.sv =====
// Top level of the partition fit allocator: configuration registers and the request sequencer.
`default_nettype none

// A load request writes one partition's free size; back-to-back loads are accepted every
// cycle. An allocation request scans the active partitions through the single read port of
// the size table, one entry per cycle, and the block takes no new request until its result
// is written to the output register; first fit stops at the first partition that fits. The
// table is cleared by reset through one valid bit per entry, so no clearing pass is needed.
// A finished result waits in an output register while the next request is accepted.
module partition_fit_allocator_unit #(
   parameter int NUM_PARTS = 16,
   parameter int SIZE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_en,
   input  wire logic [pfa_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [pfa_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire pfa_pkg::req_type                      req,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      pfa_pkg::rsp_type                      rsp
);

   pfa_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            pfa_pkg::CSR_FIT_MODE: begin
               cfg_in.fit_mode = csr_wdata[pfa_pkg::FIT_MODE_BITS-1:0];
            end
            pfa_pkg::CSR_PART_COUNT: begin
               cfg_in.part_count = csr_wdata[pfa_pkg::PART_COUNT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pfa_ctrl #(
      .NUM_PARTS (NUM_PARTS),
      .SIZE_BITS (SIZE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output      logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_ctrl.sv =====
// Request sequencer: loads the size table, scans it one entry per cycle and writes back.
`default_nettype none

module pfa_ctrl #(
   parameter int NUM_PARTS = 16,
   parameter int SIZE_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pfa_pkg::cfg_type cfg,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire pfa_pkg::req_type req,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      pfa_pkg::rsp_type rsp
);

   localparam int IW   = $clog2(NUM_PARTS);
   localparam int CW   = IW + 1;
   localparam int CMPW = (CW > pfa_pkg::PART_COUNT_BITS) ? CW : pfa_pkg::PART_COUNT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                            state_ff, state_in;
   logic [CW-1:0]                        rd_idx_ff, rd_idx_in;
   logic [IW-1:0]                        cmp_idx_ff, cmp_idx_in;
   logic                                 cmp_live_ff, cmp_live_in;
   logic                                 vld_rd_ff, vld_rd_in;
   logic [CW-1:0]                        n_ff, n_in;
   logic [SIZE_BITS-1:0]                 req_size_ff, req_size_in;
   logic [pfa_pkg::FIT_MODE_BITS-1:0]    mode_ff, mode_in;
   logic                                 found_ff, found_in;
   logic [IW-1:0]                        pick_ff, pick_in;
   logic [SIZE_BITS-1:0]                 best_ff, best_in;
   logic [NUM_PARTS-1:0]                 valid_ff, valid_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   pfa_pkg::rsp_type                     rsp_data_ff, rsp_data_in;

   logic                 mem_we;
   logic [IW-1:0]        mem_waddr;
   logic [SIZE_BITS-1:0] mem_wdata;
   logic [IW-1:0]        mem_raddr;
   logic [SIZE_BITS-1:0] mem_rdata;

   logic                 out_free;
   logic                 req_take;
   logic [CMPW-1:0]      idx_ext;
   logic [CMPW-1:0]      count_ext;
   logic [CMPW-1:0]      active;
   logic                 load_ok;
   logic [SIZE_BITS-1:0] room;
   logic                 fits;
   logic                 better;
   logic                 multi;
   logic                 last;
   logic                 issue;
   logic [SIZE_BITS-1:0] left;

   pfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_PARTS)
   ) u_table (
      .clock      (clock),
      .write_en   (mem_we),
      .write_addr (mem_waddr),
      .write_data (mem_wdata),
      .read_addr  (mem_raddr),
      .read_data  (mem_rdata)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == ST_IDLE);
      req_take  = req_valid && req_ready;
      idx_ext   = CMPW'(req.part_index);
      count_ext = CMPW'(cfg.part_count);
      load_ok   = idx_ext < CMPW'(NUM_PARTS);
      active    = (count_ext > CMPW'(NUM_PARTS)) ? CMPW'(NUM_PARTS) : count_ext;
      room      = vld_rd_ff ? mem_rdata : '0;
      fits      = room >= req_size_ff;
      multi     = (mode_ff == pfa_pkg::FIT_BEST) || (mode_ff == pfa_pkg::FIT_WORST);
      better    = !found_ff
                  || ((mode_ff == pfa_pkg::FIT_BEST) && (room < best_ff))
                  || ((mode_ff == pfa_pkg::FIT_WORST) && (room > best_ff));
      last      = cmp_live_ff
                  && ((CW'(cmp_idx_ff) == (n_ff - CW'(1))) || (fits && !multi));
      issue     = (state_ff == ST_SCAN) && (rd_idx_ff < n_ff);
      left      = best_ff - req_size_ff;
      mem_raddr = rd_idx_ff[IW-1:0];
      mem_we    = (req_take && (req.kind == pfa_pkg::KIND_LOAD) && load_ok)
                  || ((state_ff == ST_FINISH) && out_free && found_ff);
      mem_waddr = (state_ff == ST_FINISH) ? pick_ff : IW'(req.part_index);
      mem_wdata = (state_ff == ST_FINISH) ? left : SIZE_BITS'(req.size);
   end

   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_live_in  = cmp_live_ff;
      vld_rd_in    = vld_rd_ff;
      n_in         = n_ff;
      req_size_in  = req_size_ff;
      mode_in      = mode_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (mem_we) begin
         valid_in[mem_waddr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req.kind == pfa_pkg::KIND_ALLOC)) begin
               req_size_in = SIZE_BITS'(req.size);
               mode_in     = cfg.fit_mode;
               n_in        = CW'(active);
               found_in    = 1'b0;
               pick_in     = '0;
               best_in     = '0;
               rd_idx_in   = '0;
               cmp_live_in = 1'b0;
               state_in    = (active == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_live_in = issue;
            if (issue) begin
               rd_idx_in  = rd_idx_ff + CW'(1);
               cmp_idx_in = rd_idx_ff[IW-1:0];
               vld_rd_in  = valid_ff[rd_idx_ff[IW-1:0]];
            end
            if (cmp_live_ff && fits && better) begin
               found_in = 1'b1;
               pick_in  = cmp_idx_ff;
               best_in  = room;
            end
            if (last) begin
               cmp_live_in = 1'b0;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  rsp_data_in.granted     = 1'b1;
                  rsp_data_in.chosen_part = pfa_pkg::INDEX_BITS'(pick_ff);
                  rsp_data_in.left_size   = pfa_pkg::SIZE_FIELD_BITS'(left);
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_live_ff  <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_idx_ff   <= cmp_idx_in;
         cmp_live_ff  <= cmp_live_in;
         vld_rd_ff    <= vld_rd_in;
         n_ff         <= n_in;
         req_size_ff  <= req_size_in;
         mode_ff      <= mode_in;
         found_ff     <= found_in;
         pick_ff      <= pick_in;
         best_ff      <= best_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_data_ff;

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !mem_we)
      else $error("Table written during a scan.");

   a_compare_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_live_ff |-> (CW'(cmp_idx_ff) < n_ff))
      else $error("Compared entry lies beyond the active partitions.");

   a_grant_fits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && found_ff) |-> ((best_ff >= req_size_ff)
                                                && (CW'(pick_ff) < n_ff)))
      else $error("Chosen partition cannot hold the request.");

   a_refusal_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.granted) |-> ((rsp_data_ff.chosen_part == '0)
                                                 && (rsp_data_ff.left_size == '0)))
      else $error("Refused request carries a partition or size.");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench of the partition fit allocator: a directed table, then random phases.

module testbench;

   localparam int NUM_PARTS       = 16;
   localparam int SIZE_BITS       = 16;
   localparam int SETTLE_CYCLES   = NUM_PARTS + 8;
   localparam int RANDOM_PHASES   = 24;
   localparam int PHASE_ITEMS     = 48;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PRINT_LIMIT     = 40;
   localparam int DIRECTED_COUNT  = 27;

   localparam logic [pfa_pkg::FIT_MODE_BITS-1:0]  FIT_SPARE   = 2'd3;
   localparam logic [pfa_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [pfa_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;
   localparam logic [pfa_pkg::CSR_INDEX_BITS-1:0] CSR_MODE    = pfa_pkg::CSR_FIT_MODE;
   localparam logic [pfa_pkg::CSR_INDEX_BITS-1:0] CSR_COUNT   = pfa_pkg::CSR_PART_COUNT;
   localparam pfa_pkg::rsp_type REFUSED = '0;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ALLOC,
      OP_WRITE
   } step_op_type;

   typedef struct packed {
      step_op_type                         op;
      logic [pfa_pkg::CSR_INDEX_BITS-1:0]  reg_sel;
      logic [pfa_pkg::INDEX_BITS-1:0]      part;
      logic [pfa_pkg::SIZE_FIELD_BITS-1:0] value;
      logic                                check;
      pfa_pkg::rsp_type                    want;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{OP_ALLOC, CSR_MODE,    4'd0,  16'd0,      1'b1, REFUSED},
      '{OP_LOAD,  CSR_MODE,    4'd0,  16'hFFFF,   1'b0, REFUSED},
      '{OP_LOAD,  CSR_MODE,    4'd15, 16'hFFFF,   1'b0, REFUSED},
      '{OP_ALLOC, CSR_MODE,    4'd15, 16'hFFFF,   1'b1, REFUSED},
      '{OP_WRITE, CSR_COUNT,   4'd0,  16'd31,     1'b0, REFUSED},
      '{OP_ALLOC, CSR_MODE,    4'd7,  16'hFFFF,   1'b1, '{1'b1, 4'd0, 16'd0}},
      '{OP_ALLOC, CSR_MODE,    4'd0,  16'hFFFF,   1'b1, '{1'b1, 4'd15, 16'd0}},
      '{OP_ALLOC, CSR_MODE,    4'd0,  16'd0,      1'b1, '{1'b1, 4'd0, 16'd0}},
      '{OP_WRITE, CSR_COUNT,   4'd0,  16'd4,      1'b0, REFUSED},
      '{OP_WRITE, CSR_MODE,    4'd0,  {14'd0, pfa_pkg::FIT_BEST}, 1'b0, REFUSED},
      '{OP_LOAD,  CSR_MODE,    4'd0,  16'd100,    1'b0, REFUSED},
      '{OP_LOAD,  CSR_MODE,    4'd1,  16'd50,     1'b0, REFUSED},
      '{OP_LOAD,  CSR_MODE,    4'd2,  16'd200,    1'b0, REFUSED},
      '{OP_LOAD,  CSR_MODE,    4'd3,  16'd50,     1'b0, REFUSED},
      '{OP_ALLOC, CSR_MODE,    4'd0,  16'd40,     1'b1, '{1'b1, 4'd1, 16'd10}},
      '{OP_ALLOC, CSR_MODE,    4'd0,  16'd40,     1'b1, '{1'b1, 4'd3, 16'd10}},
      '{OP_WRITE, CSR_MODE,    4'd0,  {14'd0, pfa_pkg::FIT_WORST}, 1'b0, REFUSED},
      '{OP_ALLOC, CSR_MODE,    4'd0,  16'd30,     1'b1, '{1'b1, 4'd2, 16'd170}},
      '{OP_ALLOC, CSR_MODE,    4'd0,  16'd300,    1'b1, REFUSED},
      '{OP_WRITE, CSR_MODE,    4'd0,  {11'd0, 3'b111, FIT_SPARE}, 1'b0, REFUSED},
      '{OP_ALLOC, CSR_MODE,    4'd0,  16'd5,      1'b1, '{1'b1, 4'd0, 16'd95}},
      '{OP_WRITE, CSR_SPARE_A, 4'd0,  16'd1,      1'b0, REFUSED},
      '{OP_WRITE, CSR_SPARE_B, 4'd0,  16'd0,      1'b0, REFUSED},
      '{OP_ALLOC, CSR_MODE,    4'd0,  16'd5,      1'b1, '{1'b1, 4'd0, 16'd90}},
      '{OP_WRITE, CSR_COUNT,   4'd0,  16'd0,      1'b0, REFUSED},
      '{OP_ALLOC, CSR_MODE,    4'd0,  16'd0,      1'b1, REFUSED},
      '{OP_ALLOC, CSR_MODE,    4'd15, 16'hFFFF,   1'b1, REFUSED}
   };

   logic                                clock;
   logic                                reset        = 1'b1;
   logic                                csr_write_en = 1'b0;
   logic [pfa_pkg::CSR_INDEX_BITS-1:0]  csr_index    = '0;
   logic [pfa_pkg::CSR_DATA_BITS-1:0]   csr_wdata    = '0;
   logic                                req_valid    = 1'b0;
   logic                                req_ready;
   pfa_pkg::req_type                    req          = '0;
   logic                                rsp_valid;
   logic                                rsp_ready    = 1'b0;
   pfa_pkg::rsp_type                    rsp;

   logic                                req_typed    = 1'b0;
   pfa_pkg::rsp_type                    req_want     = '0;
   bit                                  steady       = 1'b0;

   logic [pfa_pkg::SIZE_FIELD_BITS-1:0] free_space [NUM_PARTS] = '{default: '0};
   logic [pfa_pkg::FIT_MODE_BITS-1:0]   policy       = '0;
   logic [pfa_pkg::PART_COUNT_BITS-1:0] scan_limit   = '0;
   pfa_pkg::rsp_type                    placement_queue [$];

   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;
   int unsigned load_count     = 0;
   int unsigned alloc_count    = 0;
   int unsigned grant_count    = 0;
   int unsigned refusal_count  = 0;
   int unsigned write_count    = 0;

   partition_fit_allocator_unit #(
      .NUM_PARTS (NUM_PARTS),
      .SIZE_BITS (SIZE_BITS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req          (req),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp          (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic pfa_pkg::rsp_type place_request(
         input logic [pfa_pkg::SIZE_FIELD_BITS-1:0] want_size);
      int unsigned      span;
      int unsigned      pick;
      bit               found;
      pfa_pkg::rsp_type outcome;
      span  = (scan_limit > NUM_PARTS) ? NUM_PARTS : scan_limit;
      found = 1'b0;
      pick  = 0;
      for (int unsigned i = 0; i < span; i++) begin
         if (free_space[i] >= want_size) begin
            if (!found) begin
               found = 1'b1;
               pick  = i;
               if (policy != pfa_pkg::FIT_BEST && policy != pfa_pkg::FIT_WORST) begin
                  break;
               end
            end else if (policy == pfa_pkg::FIT_BEST && free_space[i] < free_space[pick]) begin
               pick = i;
            end else if (policy == pfa_pkg::FIT_WORST && free_space[i] > free_space[pick]) begin
               pick = i;
            end
         end
      end
      if (found) begin
         free_space[pick]    = free_space[pick] - want_size;
         outcome.granted     = 1'b1;
         outcome.chosen_part = pfa_pkg::INDEX_BITS'(pick);
         outcome.left_size   = free_space[pick];
      end else begin
         outcome = REFUSED;
      end
      return outcome;
   endfunction

   function automatic pfa_pkg::req_type random_request();
      pfa_pkg::req_type item;
      int unsigned      span;
      int unsigned      pick;
      int unsigned      slot;
      span = (scan_limit > NUM_PARTS) ? NUM_PARTS : scan_limit;
      item.kind = ($urandom_range(0, 99) < 35) ? pfa_pkg::KIND_LOAD : pfa_pkg::KIND_ALLOC;
      item.part_index = pfa_pkg::INDEX_BITS'($urandom_range(0, NUM_PARTS - 1));
      pick = $urandom_range(0, 99);
      if (item.kind == pfa_pkg::KIND_LOAD) begin
         if (span != 0 && $urandom_range(0, 99) < 70) begin
            item.part_index = pfa_pkg::INDEX_BITS'($urandom_range(0, span - 1));
         end
         if (pick < 40) begin
            item.size = pfa_pkg::SIZE_FIELD_BITS'($urandom_range(0, 255));
         end else if (pick < 60) begin
            item.size = pfa_pkg::SIZE_FIELD_BITS'(64 << $urandom_range(0, 2));
         end else if (pick < 80) begin
            item.size = pfa_pkg::SIZE_FIELD_BITS'($urandom);
         end else if (pick < 90) begin
            item.size = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         end else begin
            item.size = pfa_pkg::SIZE_FIELD_BITS'($urandom_range(0, 4095));
         end
      end else begin
         slot = (span != 0) ? $urandom_range(0, span - 1) : $urandom_range(0, NUM_PARTS - 1);
         if (pick < 30) begin
            item.size = pfa_pkg::SIZE_FIELD_BITS'($urandom_range(0, 63));
         end else if (pick < 50) begin
            item.size = free_space[slot];
         end else if (pick < 65) begin
            item.size = '0;
         end else if (pick < 85) begin
            item.size = pfa_pkg::SIZE_FIELD_BITS'($urandom);
         end else begin
            item.size = pfa_pkg::SIZE_FIELD_BITS'($urandom_range(0, 1023));
         end
      end
      return item;
   endfunction

   task automatic report_mismatch(input string what, input pfa_pkg::rsp_type got,
                                  input pfa_pkg::rsp_type want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("MISMATCH cycle %0d: %s: got %0d/%0d/%0d, expected %0d/%0d/%0d", cycle_count,
                  what, got.granted, got.chosen_part, got.left_size,
                  want.granted, want.chosen_part, want.left_size);
      end
   endtask

   task automatic push_request(input pfa_pkg::req_type item, input logic check,
                               input pfa_pkg::rsp_type want);
      while (!steady && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      req_typed <= check;
      req_want  <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (placement_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [pfa_pkg::CSR_INDEX_BITS-1:0] sel,
                            input logic [pfa_pkg::CSR_DATA_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= sel;
      csr_wdata    <= data;
      @(posedge clock);
      if (sel == pfa_pkg::CSR_FIT_MODE) begin
         policy = data[pfa_pkg::FIT_MODE_BITS-1:0];
      end else if (sel == pfa_pkg::CSR_PART_COUNT) begin
         scan_limit = data;
      end
      write_count++;
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d results outstanding.",
                  placement_queue.size());
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin : scoreboard
      pfa_pkg::rsp_type want;
      pfa_pkg::rsp_type outcome;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (placement_queue.size() == 0) begin
               report_mismatch("result with no request outstanding", rsp, REFUSED);
            end else begin
               want = placement_queue.pop_front();
               if (rsp.granted !== want.granted) begin
                  report_mismatch("granted", rsp, want);
               end
               if (rsp.chosen_part !== want.chosen_part) begin
                  report_mismatch("chosen_part", rsp, want);
               end
               if (rsp.left_size !== want.left_size) begin
                  report_mismatch("left_size", rsp, want);
               end
               if (want.granted) begin
                  grant_count++;
               end else begin
                  refusal_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req.kind == pfa_pkg::KIND_LOAD) begin
               free_space[req.part_index] = req.size;
               load_count++;
            end else begin
               outcome = place_request(req.size);
               placement_queue.push_back(req_typed ? req_want : outcome);
               alloc_count++;
            end
         end
      end
      rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 36);
   end

   initial begin
      directed_row_type                    row;
      pfa_pkg::req_type                    item;
      logic [pfa_pkg::FIT_MODE_BITS-1:0]   mode;
      logic [pfa_pkg::PART_COUNT_BITS-1:0] count;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.op == OP_WRITE) begin
            settle();
            write_csr(row.reg_sel, row.value[pfa_pkg::CSR_DATA_BITS-1:0]);
         end else begin
            item.kind       = (row.op == OP_LOAD) ? pfa_pkg::KIND_LOAD : pfa_pkg::KIND_ALLOC;
            item.part_index = row.part;
            item.size       = row.value;
            push_request(item, row.check, row.want);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         steady = (phase >= 10 && phase < 13);
         case (phase % 4)
            0: mode = pfa_pkg::FIT_FIRST;
            1: mode = pfa_pkg::FIT_BEST;
            2: mode = pfa_pkg::FIT_WORST;
            default: mode = FIT_SPARE;
         endcase
         case (phase % 6)
            0: count = pfa_pkg::PART_COUNT_BITS'(NUM_PARTS);
            1: count = pfa_pkg::PART_COUNT_BITS'($urandom_range(1, NUM_PARTS - 1));
            2: count = '1;
            3: count = pfa_pkg::PART_COUNT_BITS'(1);
            4: count = pfa_pkg::PART_COUNT_BITS'($urandom_range(NUM_PARTS + 1, 30));
            default: count = pfa_pkg::PART_COUNT_BITS'($urandom_range(0, NUM_PARTS));
         endcase
         write_csr(pfa_pkg::CSR_FIT_MODE, {3'($urandom), mode});
         write_csr(pfa_pkg::CSR_PART_COUNT, count);
         if (phase % 3 == 0) begin
            write_csr((phase % 2 != 0) ? CSR_SPARE_A : CSR_SPARE_B,
                      pfa_pkg::CSR_DATA_BITS'($urandom));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            push_request(random_request(), 1'b0, REFUSED);
         end
      end
      steady = 1'b0;
      settle();

      $display("Covered %0d loads and %0d allocation requests across %0d register writes.",
               load_count, alloc_count, write_count);
      $display("Allocations granted: %0d, refused: %0d, mismatches: %0d.",
               grant_count, refusal_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
